FILE: hdl/dbt_pkg.sv
// Shared types, codes and constants for the DFU block transfer engine.
package dbt_pkg;

  localparam int EP_SIZE_DEFAULT = 64;
  localparam int QUEUE_DEPTH = 2;

  // Request kinds as they arrive on the input channel
  localparam logic [2:0] KIND_DNLOAD = 3'd0;
  localparam logic [2:0] KIND_UPLOAD = 3'd1;
  localparam logic [2:0] KIND_ABORT  = 3'd2;
  localparam logic [2:0] KIND_DETACH = 3'd3;

  // Data stage actions
  localparam logic [1:0] ACT_NONE   = 2'd0;
  localparam logic [1:0] ACT_RECV   = 2'd1;
  localparam logic [1:0] ACT_SEND   = 2'd2;
  localparam logic [1:0] ACT_COMMON = 2'd3;

  // Reported protocol state codes
  localparam logic [1:0] STATE_CODE_IDLE   = 2'd0;
  localparam logic [1:0] STATE_CODE_DNIDLE = 2'd1;
  localparam logic [1:0] STATE_CODE_UPIDLE = 2'd2;
  localparam logic [1:0] STATE_CODE_ERROR  = 2'd3;

  // Status codes
  localparam logic [1:0] STS_OK      = 2'd0;
  localparam logic [1:0] STS_ADDR    = 2'd1;
  localparam logic [1:0] STS_UNKNOWN = 2'd2;

  typedef enum logic [4:0] {
    CLS_DNLOAD = 5'b00001,
    CLS_UPLOAD = 5'b00010,
    CLS_ABORT  = 5'b00100,
    CLS_DETACH = 5'b01000,
    CLS_OTHER  = 5'b10000
  } req_class_t;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_DNIDLE = 4'b0010,
    ST_UPIDLE = 4'b0100,
    ST_ERROR  = 4'b1000
  } dfu_state_t;

  // Classified request as it waits in the queue
  typedef struct packed {
    req_class_t  cls;
    logic [15:0] block_num;
    logic        len_zero;
    logic        len_over;
    logic        flash_room;
    logic        short_read;
    logic [6:0]  data_len;
  } op_t;

  typedef struct packed {
    logic       accept;
    logic [1:0] action;
    logic [6:0] send_length;
    logic       flash_begin;
    logic       flash_finish;
    logic [1:0] state_now;
    logic [1:0] status_now;
    logic       download_done;
  } rsp_t;

endpackage

FILE: hdl/dbt_in_if.sv
// Request channel: valid/ready handshake with the request fields.
interface dbt_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [15:0] block_num;
  logic [15:0] req_length;
  logic        flash_room;
  logic [6:0]  flash_avail;

  modport source (output valid, kind, block_num, req_length, flash_room, flash_avail,
                  input ready);
  modport sink (input valid, kind, block_num, req_length, flash_room, flash_avail,
                output ready);
endinterface

FILE: hdl/dbt_out_if.sv
// Result channel: valid/ready handshake with the response fields.
interface dbt_out_if;
  logic       valid;
  logic       ready;
  logic       accept;
  logic [1:0] action;
  logic [6:0] send_length;
  logic       flash_begin;
  logic       flash_finish;
  logic [1:0] state_now;
  logic [1:0] status_now;
  logic       download_done;

  modport source (output valid, accept, action, send_length, flash_begin, flash_finish,
                  state_now, status_now, download_done, input ready);
  modport sink (input valid, accept, action, send_length, flash_begin, flash_finish,
                state_now, status_now, download_done, output ready);
endinterface

FILE: hdl/dbt_front.sv
// Request front end: decode the kind and precompute the length checks.
module dbt_front import dbt_pkg::*; #(
  parameter int EP_SIZE = EP_SIZE_DEFAULT
) (
  input  logic [2:0]  kind,
  input  logic [15:0] block_num,
  input  logic [15:0] req_length,
  input  logic        flash_room,
  input  logic [6:0]  flash_avail,
  output op_t         op
);

  localparam logic [15:0] LEN_LIMIT = 16'(EP_SIZE);

  req_class_t cls;
  logic       short_read;

  always_comb begin
    unique case (kind)
      KIND_DNLOAD: cls = CLS_DNLOAD;
      KIND_UPLOAD: cls = CLS_UPLOAD;
      KIND_ABORT:  cls = CLS_ABORT;
      KIND_DETACH: cls = CLS_DETACH;
      default:     cls = CLS_OTHER;
    endcase
  end

  assign short_read = {9'd0, flash_avail} < req_length;

  always_comb begin
    op.cls        = cls;
    op.block_num  = block_num;
    op.len_zero   = (req_length == 16'd0);
    op.len_over   = (req_length > LEN_LIMIT);
    op.flash_room = flash_room;
    op.short_read = short_read;
    // an upload short read sends only what flash has
    op.data_len   = (cls == CLS_UPLOAD && short_read) ? flash_avail : req_length[6:0];
  end

endmodule

FILE: hdl/dbt_queue.sv
// Small FIFO between the request front end and the protocol engine.
module dbt_queue import dbt_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  op_t  push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output op_t  pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  op_t           mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          push;
  logic          pop;

  assign push_ready = (count != FULL);
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

FILE: hdl/dbt_back.sv
// Protocol engine: DFU state, block tracking and the registered result.
module dbt_back import dbt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic op_valid,
  output logic op_ready,
  input  op_t  op,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp_data
);

  dfu_state_t  state, state_next;
  logic [1:0]  status, status_next;
  logic [15:0] exp_blk, exp_blk_next;
  logic        done, done_next;

  logic        fresh;
  logic [15:0] prev_blk;
  logic [15:0] cur_exp;
  rsp_t        res;
  logic        step;

  assign op_ready = !rsp_valid || rsp_ready;
  assign step     = op_valid && op_ready;
  assign fresh    = (state == ST_IDLE);
  assign prev_blk = exp_blk - 16'd1;
  // a fresh session starts at the block number it carries
  assign cur_exp  = fresh ? op.block_num : exp_blk;

  always_comb begin
    state_next        = state;
    status_next       = status;
    exp_blk_next      = exp_blk;
    done_next         = done;
    res.accept        = 1'b1;
    res.action        = ACT_NONE;
    res.send_length   = 7'd0;
    res.flash_begin   = 1'b0;
    res.flash_finish  = 1'b0;

    unique case (op.cls)
      CLS_DNLOAD: begin
        if (fresh) begin
          exp_blk_next    = op.block_num;
          res.flash_begin = 1'b1;
        end
        priority if (!fresh && state != ST_DNIDLE) begin
          res.accept = 1'b0;
        end else if (!fresh && op.block_num == prev_blk) begin
          // retransmission: acknowledge only
        end else if (op.block_num != cur_exp) begin
          state_next  = ST_ERROR;
          status_next = STS_UNKNOWN;
        end else if (op.len_zero) begin
          res.flash_finish = 1'b1;
          state_next       = ST_IDLE;
          done_next        = 1'b1;
        end else begin
          priority if (!op.flash_room) begin
            state_next  = ST_ERROR;
            status_next = STS_ADDR;
            res.accept  = 1'b0;
          end else if (op.len_over) begin
            state_next  = ST_ERROR;
            status_next = STS_UNKNOWN;
            res.accept  = 1'b0;
          end else begin
            res.action      = ACT_RECV;
            res.send_length = op.data_len;
            state_next      = ST_DNIDLE;
          end
          exp_blk_next = cur_exp + 16'd1;
        end
      end
      CLS_UPLOAD: begin
        if (fresh) begin
          exp_blk_next    = op.block_num;
          res.flash_begin = 1'b1;
        end
        priority if (!fresh && state != ST_UPIDLE) begin
          res.accept = 1'b0;
        end else if ((!fresh && op.block_num == prev_blk) || op.block_num != cur_exp) begin
          state_next  = ST_ERROR;
          status_next = STS_UNKNOWN;
        end else begin
          if (op.len_over) begin
            state_next  = ST_ERROR;
            status_next = STS_UNKNOWN;
          end else begin
            res.action      = ACT_SEND;
            res.send_length = op.data_len;
            // a short read closes the upload
            state_next      = op.short_read ? ST_IDLE : ST_UPIDLE;
          end
          exp_blk_next = cur_exp + 16'd1;
        end
      end
      CLS_ABORT: begin
        state_next  = ST_IDLE;
        status_next = STS_OK;
      end
      CLS_DETACH: begin
      end
      default: begin
        res.action = ACT_COMMON;
      end
    endcase

    unique case (state_next)
      ST_IDLE:   res.state_now = STATE_CODE_IDLE;
      ST_DNIDLE: res.state_now = STATE_CODE_DNIDLE;
      ST_UPIDLE: res.state_now = STATE_CODE_UPIDLE;
      default:   res.state_now = STATE_CODE_ERROR;
    endcase
    res.status_now    = status_next;
    res.download_done = done_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      status    <= STS_OK;
      exp_blk   <= 16'd0;
      done      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (step) begin
        state   <= state_next;
        status  <= status_next;
        exp_blk <= exp_blk_next;
        done    <= done_next;
      end
      if (op_ready) begin
        rsp_valid <= op_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      rsp_data <= res;
    end
  end

endmodule

FILE: hdl/dfu_block_transfer_fsm_core.sv
// Top level of the DFU block transfer engine: front end, queue and protocol engine.
//
//   channel  dir  handshake            fields
//   req      in   req.valid/req.ready  kind block_num req_length flash_room flash_avail
//   rsp      out  rsp.valid/rsp.ready  accept action send_length flash_begin flash_finish
//                                      state_now status_now download_done
//
// One request per clock is taken and one result per clock is given when neither side
// stalls; a request is first written into the queue, then the protocol engine registers
// its result, which is held in the result register until rsp.ready takes it.
// The queue holds QUEUE_DEPTH requests; req.ready drops only when it is full, which
// happens when rsp.ready has been low long enough to fill the result register and queue.
// Reset is synchronous: the DFU state returns to idle with status ok, the expected block
// to zero, the download-done flag clears and both the queue and the result register empty.
module dfu_block_transfer_fsm_core import dbt_pkg::*; #(
  parameter int EP_SIZE = EP_SIZE_DEFAULT
) (
  input logic      clk,
  input logic      rst,
  dbt_in_if.sink   req,
  dbt_out_if.source rsp
);

  op_t  front_op;
  op_t  head_op;
  logic head_valid;
  logic head_ready;
  rsp_t rsp_data;
  logic rsp_valid;

  // Classify requests as they arrive
  dbt_front #(
    .EP_SIZE (EP_SIZE)
  ) u_front (
    .kind        (req.kind),
    .block_num   (req.block_num),
    .req_length  (req.req_length),
    .flash_room  (req.flash_room),
    .flash_avail (req.flash_avail),
    .op          (front_op)
  );

  // Decouple intake from the protocol engine
  dbt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (req.valid),
    .push_ready (req.ready),
    .push_data  (front_op),
    .pop_valid  (head_valid),
    .pop_ready  (head_ready),
    .pop_data   (head_op)
  );

  // Apply each request to the DFU state and hold the result until taken
  dbt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (head_valid),
    .op_ready  (head_ready),
    .op        (head_op),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp_data)
  );

  assign rsp.valid         = rsp_valid;
  assign rsp.accept        = rsp_data.accept;
  assign rsp.action        = rsp_data.action;
  assign rsp.send_length   = rsp_data.send_length;
  assign rsp.flash_begin   = rsp_data.flash_begin;
  assign rsp.flash_finish  = rsp_data.flash_finish;
  assign rsp.state_now     = rsp_data.state_now;
  assign rsp.status_now    = rsp_data.status_now;
  assign rsp.download_done = rsp_data.download_done;

`ifndef NO_ASSERTIONS
  // Error state and a nonzero status always go together
  a_err_status: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> ((rsp_data.state_now == STATE_CODE_ERROR) ==
                   (rsp_data.status_now != STS_OK)))
    else $error("error state and status disagree");

  // The closing empty block leaves the engine idle with the download marked done
  a_finish: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.flash_finish |->
      rsp_data.accept && rsp_data.action == ACT_NONE &&
      rsp_data.state_now == STATE_CODE_IDLE && rsp_data.download_done)
    else $error("flash finish with inconsistent result");

  // A data stage never exceeds one endpoint packet, and only data stages carry a length
  a_len: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.send_length != 7'd0 |->
      (rsp_data.action == ACT_RECV || rsp_data.action == ACT_SEND) &&
      {25'd0, rsp_data.send_length} <= 32'(EP_SIZE))
    else $error("data stage length out of range");

  // A request stuck at the queue head is held until the engine takes it
  a_head_hold: assert property (@(posedge clk) disable iff (rst)
    head_valid && !head_ready |=> head_valid && $stable(head_op))
    else $error("queue head changed while stalled");
`endif

endmodule

FILE: test/tb_dfu_block_transfer_fsm_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for the DFU block transfer engine: directed and random requests.
module tb_dfu_block_transfer_fsm_core;
  import dbt_pkg::*;

  localparam int         EP           = EP_SIZE_DEFAULT;
  localparam logic [2:0] KIND_OTHER   = 3'd4;
  localparam int         RANDOM_ITEMS = 650;
  localparam int         CYCLE_LIMIT  = 200000;
  localparam int         DRAIN_CYCLES = 20;
  localparam int         MAX_REPORTS  = 10;

  // Receiver behavior: always ready, random bit pattern, or rare long stalls
  typedef enum int {RX_ALWAYS, RX_PATTERN, RX_LONG} rx_mode_t;

  logic clk;
  logic rst;

  dbt_in_if  req_ch();
  dbt_out_if rsp_ch();

  dfu_block_transfer_fsm_core #(.EP_SIZE(EP)) u_top (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // Shadow of the DFU protocol state, advanced once per accepted request
  logic [1:0]  dfu_state;
  logic [1:0]  dfu_status;
  logic [15:0] next_blk;
  logic        done_flag;

  // Responses predicted for accepted requests, oldest first
  rsp_t expected_rsps[$];

  int unsigned sent_count;
  int unsigned checked_count;
  int unsigned error_count;
  int unsigned finish_count;
  int unsigned short_read_count;
  int unsigned error_entry_count;
  int unsigned stall_count;
  int unsigned cycle_count;

  // Sender pacing and receiver stall controls
  bit          gaps_on;
  int unsigned burst_left;
  rx_mode_t    rx_mode;
  logic [31:0] rx_word;
  int unsigned rx_phase;
  int unsigned rx_hold;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic logic [15:0] rand16();
    logic [31:0] w;
    w = $urandom;
    return w[15:0];
  endfunction

  function automatic logic [6:0] rand_avail();
    logic [31:0] w;
    w = $urandom_range(0, EP);
    return w[6:0];
  endfunction

  function automatic string fmt_rsp(rsp_t r);
    return $sformatf("acc=%0d act=%0d len=%0d beg=%0d fin=%0d st=%0d sts=%0d done=%0d",
                     r.accept, r.action, r.send_length, r.flash_begin, r.flash_finish,
                     r.state_now, r.status_now, r.download_done);
  endfunction

  function automatic void log_error(string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("ERROR: %s", msg);
  endfunction

  function automatic void enter_error(logic [1:0] code);
    dfu_state  = STATE_CODE_ERROR;
    dfu_status = code;
    error_entry_count++;
  endfunction

  // Compute the response to one request and advance the shadow state
  function automatic rsp_t predict_rsp(logic [2:0] kind, logic [15:0] blk, logic [15:0] len,
                                       logic room, logic [6:0] avail);
    rsp_t        r;
    logic        fresh;
    logic [15:0] prev_blk;
    r        = '0;
    r.accept = 1'b1;
    r.action = ACT_NONE;
    prev_blk = next_blk - 16'd1;
    fresh    = (dfu_state == STATE_CODE_IDLE);
    case (kind)
      KIND_DNLOAD: begin
        // A download from idle opens a session at whatever block it carries
        if (fresh) begin
          next_blk      = blk;
          r.flash_begin = 1'b1;
        end
        if (!fresh && dfu_state != STATE_CODE_DNIDLE) begin
          r.accept = 1'b0;
        end else if (!fresh && blk == prev_blk) begin
          // repeated block: acknowledge, nothing moves
        end else if (blk != next_blk) begin
          enter_error(STS_UNKNOWN);
        end else if (len == 16'd0) begin
          r.flash_finish = 1'b1;
          dfu_state      = STATE_CODE_IDLE;
          done_flag      = 1'b1;
          finish_count++;
        end else begin
          if (!room) begin
            enter_error(STS_ADDR);
            r.accept = 1'b0;
          end else if (len > EP) begin
            enter_error(STS_UNKNOWN);
            r.accept = 1'b0;
          end else begin
            r.action      = ACT_RECV;
            r.send_length = len[6:0];
            dfu_state     = STATE_CODE_DNIDLE;
          end
          // a refused block still counts toward the sequence
          next_blk = next_blk + 16'd1;
        end
      end
      KIND_UPLOAD: begin
        if (fresh) begin
          next_blk      = blk;
          r.flash_begin = 1'b1;
        end
        if (!fresh && dfu_state != STATE_CODE_UPIDLE) begin
          r.accept = 1'b0;
        end else if ((!fresh && blk == prev_blk) || blk != next_blk) begin
          enter_error(STS_UNKNOWN);
        end else begin
          if (len > EP) begin
            enter_error(STS_UNKNOWN);
          end else begin
            r.action = ACT_SEND;
            if (avail < len) begin
              // short read ends the upload
              r.send_length = avail;
              dfu_state     = STATE_CODE_IDLE;
              short_read_count++;
            end else begin
              r.send_length = len[6:0];
              dfu_state     = STATE_CODE_UPIDLE;
            end
          end
          next_blk = next_blk + 16'd1;
        end
      end
      KIND_ABORT: begin
        dfu_state  = STATE_CODE_IDLE;
        dfu_status = STS_OK;
      end
      KIND_DETACH: begin
        // acknowledge only
      end
      default: begin
        r.action = ACT_COMMON;
      end
    endcase
    if (!r.accept) stall_count++;
    r.state_now     = dfu_state;
    r.status_now    = dfu_status;
    r.download_done = done_flag;
    return r;
  endfunction

  // Hold valid through bursts, drop it for a random gap when a burst runs out
  task automatic pace_sender();
    if (!gaps_on) return;
    if (burst_left != 0) burst_left--;
    if (burst_left == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
  endtask

  // Present one request at the falling edge and wait for the handshake
  task automatic send_request(logic [2:0] kind, logic [15:0] blk, logic [15:0] len,
                              logic room, logic [6:0] avail);
    req_ch.valid      <= 1'b1;
    req_ch.kind       <= kind;
    req_ch.block_num  <= blk;
    req_ch.req_length <= len;
    req_ch.flash_room <= room;
    req_ch.flash_avail <= avail;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    expected_rsps.push_back(predict_rsp(kind, blk, len, room, avail));
    sent_count++;
    @(negedge clk);
    pace_sender();
  endtask

  // Receiver: change ready only at the falling edge, following the current mode
  always @(negedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_ALWAYS: begin
          rsp_ch.ready <= 1'b1;
        end
        RX_PATTERN: begin
          // reload a mostly-ready pattern once every bit of the word has been used
          if (rx_phase == 0) rx_word = $urandom | $urandom;
          rsp_ch.ready <= rx_word[rx_phase[4:0]];
          rx_phase = (rx_phase + 1) % 32;
        end
        default: begin
          if (rx_hold == 0 && $urandom_range(0, 15) == 0) rx_hold = $urandom_range(5, 30);
          if (rx_hold != 0) rx_hold--;
          rsp_ch.ready <= (rx_hold == 0);
        end
      endcase
    end
  end

  // Compare every accepted response with the oldest prediction
  always @(posedge clk) begin : rsp_monitor
    rsp_t got;
    rsp_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got.accept        = rsp_ch.accept;
      got.action        = rsp_ch.action;
      got.send_length   = rsp_ch.send_length;
      got.flash_begin   = rsp_ch.flash_begin;
      got.flash_finish  = rsp_ch.flash_finish;
      got.state_now     = rsp_ch.state_now;
      got.status_now    = rsp_ch.status_now;
      got.download_done = rsp_ch.download_done;
      if (expected_rsps.size() == 0) begin
        log_error($sformatf("response with none pending: %s", fmt_rsp(got)));
      end else begin
        want = expected_rsps.pop_front();
        checked_count++;
        if (got !== want)
          log_error($sformatf("response %0d mismatch\n  expected %s\n  actual   %s",
                              checked_count, fmt_rsp(want), fmt_rsp(got)));
      end
    end
  end

  // Watchdog on total run length
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d responses pending",
               cycle_count, expected_rsps.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Detach, other and unused kinds from reset
  task automatic test_misc_requests();
    rx_mode = RX_PATTERN;
    send_request(KIND_DETACH, 16'hFFFF, 16'hFFFF, 1'b1, 7'd64);
    send_request(KIND_OTHER, 16'h0000, 16'h0000, 1'b0, 7'd0);
    send_request(3'd7, 16'hAAAA, 16'h5555, 1'b1, 7'd64);
  endtask

  // Good download with block number wrap, a retransmission and both ends
  task automatic test_download_flow();
    rx_mode = RX_ALWAYS;
    send_request(KIND_DNLOAD, 16'hFFFF, 16'(EP), 1'b1, 7'd0);
    send_request(KIND_DNLOAD, 16'hFFFF, 16'(EP), 1'b1, 7'd0);
    send_request(KIND_DNLOAD, 16'h0000, 16'd1, 1'b1, 7'd0);
    send_request(KIND_DNLOAD, 16'h0001, 16'd0, 1'b1, 7'd0);
    // zero-length block straight from idle: begin and finish together
    send_request(KIND_DNLOAD, 16'h1234, 16'd0, 1'b0, 7'd0);
  endtask

  // Wrong state, wrong block, no flash room and an oversized block
  task automatic test_download_faults();
    rx_mode = RX_LONG;
    send_request(KIND_DNLOAD, 16'd10, 16'd8, 1'b1, 7'd0);
    send_request(KIND_UPLOAD, 16'd11, 16'd8, 1'b1, 7'd64);
    send_request(KIND_DNLOAD, 16'd20, 16'd8, 1'b1, 7'd0);
    send_request(KIND_DNLOAD, 16'd11, 16'd8, 1'b1, 7'd0);
    send_request(KIND_ABORT, 16'd0, 16'd0, 1'b0, 7'd0);
    send_request(KIND_DNLOAD, 16'd3, 16'd5, 1'b0, 7'd0);
    send_request(KIND_UPLOAD, 16'd4, 16'd5, 1'b1, 7'd64);
    send_request(KIND_ABORT, 16'd0, 16'd0, 1'b0, 7'd0);
    send_request(KIND_DNLOAD, 16'd0, 16'(EP + 1), 1'b1, 7'd0);
  endtask

  // Upload: full blocks, repeated block, short read, empty read, oversized read
  task automatic test_upload_flow();
    rx_mode = RX_PATTERN;
    send_request(KIND_ABORT, 16'd0, 16'd0, 1'b0, 7'd0);
    send_request(KIND_UPLOAD, 16'd0, 16'(EP), 1'b1, 7'd64);
    send_request(KIND_UPLOAD, 16'd1, 16'd10, 1'b1, 7'd64);
    send_request(KIND_UPLOAD, 16'd1, 16'd10, 1'b1, 7'd64);
    send_request(KIND_ABORT, 16'd0, 16'd0, 1'b0, 7'd0);
    send_request(KIND_UPLOAD, 16'd100, 16'd32, 1'b0, 7'd5);
    send_request(KIND_UPLOAD, 16'd7, 16'd0, 1'b0, 7'd0);
    send_request(KIND_UPLOAD, 16'd8, 16'hFFFF, 1'b1, 7'd64);
  endtask

  // Leave any open state so that the next session starts from idle
  task automatic back_to_idle();
    if (dfu_state != STATE_CODE_IDLE)
      send_request(KIND_ABORT, rand16(), rand16(), 1'($urandom_range(0, 1)), rand_avail());
  endtask

  task automatic run_download_session();
    int unsigned n_blocks;
    int unsigned roll;
    logic [15:0] start_blk;
    logic [15:0] len;
    back_to_idle();
    // start near the wrap point now and then
    start_blk = ($urandom_range(0, 5) == 0) ? 16'hFFFF - 16'($urandom_range(0, 3)) : rand16();
    n_blocks  = $urandom_range(0, 6);
    for (int i = 0; i < n_blocks; i++) begin
      if (dfu_state == STATE_CODE_DNIDLE && $urandom_range(0, 7) == 0)
        send_request(KIND_DNLOAD, next_blk - 16'd1, 16'($urandom_range(0, EP)),
                     1'($urandom_range(0, 1)), rand_avail());
      roll = $urandom_range(0, 39);
      len  = (roll == 0) ? 16'($urandom_range(EP + 1, 65535)) : 16'($urandom_range(1, EP));
      send_request(KIND_DNLOAD, (dfu_state == STATE_CODE_IDLE) ? start_blk : next_blk, len,
                   roll != 1, rand_avail());
      if (dfu_state != STATE_CODE_DNIDLE) return;
    end
    // close with the empty block most of the time
    if ($urandom_range(0, 4) != 0)
      send_request(KIND_DNLOAD, (dfu_state == STATE_CODE_IDLE) ? start_blk : next_blk, 16'd0,
                   1'($urandom_range(0, 1)), rand_avail());
  endtask

  task automatic run_upload_session();
    int unsigned n_blocks;
    logic [15:0] start_blk;
    logic [15:0] len;
    logic [6:0]  avail;
    back_to_idle();
    start_blk = ($urandom_range(0, 5) == 0) ? 16'hFFFF - 16'($urandom_range(0, 3)) : rand16();
    n_blocks  = $urandom_range(1, 8);
    for (int i = 0; i < n_blocks; i++) begin
      if (dfu_state == STATE_CODE_UPIDLE && $urandom_range(0, 9) == 0) begin
        send_request(KIND_UPLOAD, next_blk - 16'd1, 16'($urandom_range(0, EP)),
                     1'($urandom_range(0, 1)), rand_avail());
        return;
      end
      if ($urandom_range(0, 29) == 0) begin
        len   = 16'($urandom_range(EP + 1, 65535));
        avail = rand_avail();
      end else begin
        len = 16'($urandom_range(0, EP));
        // a nonempty last block of the session reads short
        if (i == n_blocks - 1 && len != 16'd0) avail = 7'($urandom_range(0, len - 1));
        else avail = 7'($urandom_range(len, EP));
      end
      send_request(KIND_UPLOAD, (dfu_state == STATE_CODE_IDLE) ? start_blk : next_blk, len,
                   1'($urandom_range(0, 1)), avail);
      if (dfu_state != STATE_CODE_UPIDLE) return;
    end
  endtask

  // Any kind, block number close to or far from the expected one, any length
  task automatic send_noise();
    logic [31:0] w;
    logic [15:0] blk;
    logic [15:0] len;
    w = $urandom;
    case ($urandom_range(0, 2))
      0:       blk = next_blk;
      1:       blk = next_blk - 16'd1;
      default: blk = rand16();
    endcase
    case ($urandom_range(0, 3))
      0:       len = 16'd0;
      1:       len = 16'($urandom_range(1, EP));
      2:       len = rand16();
      default: len = 16'(EP + 1);
    endcase
    send_request(w[2:0], blk, len, w[3], rand_avail());
  endtask

  task automatic test_random_traffic();
    int unsigned start;
    int unsigned next_shuffle;
    int unsigned roll;
    start        = sent_count;
    next_shuffle = sent_count;
    while (sent_count - start < RANDOM_ITEMS) begin
      // reshuffle pacing now and then; both off gives a stretch with no idling
      if (sent_count >= next_shuffle) begin
        rx_mode      = rx_mode_t'($urandom_range(0, 2));
        gaps_on      = ($urandom_range(0, 3) != 0);
        burst_left   = $urandom_range(1, 12);
        next_shuffle = sent_count + $urandom_range(40, 90);
      end
      roll = $urandom_range(0, 9);
      if (roll < 4) run_download_session();
      else if (roll < 7) run_upload_session();
      else send_noise();
    end
  endtask

  initial begin
    rst                = 1'b1;
    req_ch.valid       = 1'b0;
    req_ch.kind        = 3'd0;
    req_ch.block_num   = 16'd0;
    req_ch.req_length  = 16'd0;
    req_ch.flash_room  = 1'b0;
    req_ch.flash_avail = 7'd0;

    dfu_state  = STATE_CODE_IDLE;
    dfu_status = STS_OK;
    next_blk   = 16'd0;
    done_flag  = 1'b0;

    sent_count        = 0;
    checked_count     = 0;
    error_count       = 0;
    finish_count      = 0;
    short_read_count  = 0;
    error_entry_count = 0;
    stall_count       = 0;
    cycle_count       = 0;

    gaps_on    = 1'b1;
    burst_left = 1;
    rx_mode    = RX_ALWAYS;
    rx_word    = '0;
    rx_phase   = 0;
    rx_hold    = 0;

    // hold reset, then release it at a falling edge
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    test_misc_requests();
    test_download_flow();
    test_download_faults();
    test_upload_flow();
    test_random_traffic();

    // drain: drop valid and wait for every response before the summary
    req_ch.valid <= 1'b0;
    while (expected_rsps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    error_count += expected_rsps.size();

    $display("Sent %0d requests, checked %0d responses, %0d stalled, %0d error entries",
             sent_count, checked_count, stall_count, error_entry_count);
    $display("Completed downloads: %0d, upload short reads: %0d",
             finish_count, short_read_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/dbt_pkg.sv
hdl/dbt_in_if.sv
hdl/dbt_out_if.sv
hdl/dbt_front.sv
hdl/dbt_queue.sv
hdl/dbt_back.sv
hdl/dfu_block_transfer_fsm_core.sv
test/tb_dfu_block_transfer_fsm_core.sv
